// ----- rtl/core/gsd_pkg.sv -----
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared types and constants of the gyro stall detector: field widths,
// status codes, register indexes and the control word of the sample cells.
// ----------------------------------------------------------------------------
package gsd_pkg;

   // widths of the fixed fields
   localparam int RATE_W  = 24;
   localparam int SMP_W   = 25;
   localparam int THR_W   = 30;
   localparam int LIMIT_W = 16;
   localparam int COUNT_W = 17;
   localparam int INDEX_W = 2;

   // Q.16 one and the reset sum of one sample (1.0 on each of three axes)
   localparam logic [SMP_W-1:0] ONE_Q16  = SMP_W'(65536);
   localparam logic [SMP_W-1:0] INIT_SMP = SMP_W'(3 * 65536);

   // reported window sum saturates here
   localparam logic [THR_W-1:0] SUM_MAX = {THR_W{1'b1}};

   // register reset values
   localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(65536);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

   // register indexes
   typedef enum logic [INDEX_W-1:0] {
      CSR_STALL_THRESHOLD = 2'd0,
      CSR_BAIL_LIMIT      = 2'd1
   } csr_index_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_MOVING  = 2'd0,
      STATUS_STALLED = 2'd1,
      STATUS_BAIL    = 2'd2,
      STATUS_ERROR   = 2'd3
   } status_type;

   // control word broadcast to every sample cell
   typedef struct packed {
      logic shift;
      logic init;
   } cell_ctl_type;

endpackage

// ----- rtl/core/gsd_cell.sv -----
// ----------------------------------------------------------------------------
// gsd_cell
// One window slot: holds the absolute rate sum of one sample and hands it to
// the next cell when the window advances.
// ----------------------------------------------------------------------------
module gsd_cell #(
   parameter logic [24:0] INIT_VAL = 25'd0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gsd_pkg::cell_ctl_type       ctl,
   input  logic [gsd_pkg::SMP_W-1:0]   smp_in,
   output logic [gsd_pkg::SMP_W-1:0]   smp_out
);

   logic [gsd_pkg::SMP_W-1:0] smp_ff;
   logic [gsd_pkg::SMP_W-1:0] smp_in_w;

   // init wins over shift, else hold
   always_comb begin
      smp_in_w = smp_ff;
      if (ctl.init) begin
         smp_in_w = INIT_VAL;
      end else if (ctl.shift) begin
         smp_in_w = smp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_ff <= INIT_VAL;
      end else begin
         smp_ff <= smp_in_w;
      end
   end

   assign smp_out = smp_ff;

endmodule

// ----- rtl/core/gsd_abs_stage.sv -----
// ----------------------------------------------------------------------------
// gsd_abs_stage
// Input stage: takes the magnitudes of the three rates and registers their
// sum together with the sensor failure flag.
// ----------------------------------------------------------------------------
module gsd_abs_stage (
   input  logic                               clock,
   input  logic                               load,
   input  logic signed [gsd_pkg::RATE_W-1:0]  rate_x,
   input  logic signed [gsd_pkg::RATE_W-1:0]  rate_y,
   input  logic signed [gsd_pkg::RATE_W-1:0]  rate_z,
   input  logic                               read_failed,
   output logic [gsd_pkg::SMP_W-1:0]          smp_sum,
   output logic                               failed
);

   logic [gsd_pkg::RATE_W-1:0] mag_x;
   logic [gsd_pkg::RATE_W-1:0] mag_y;
   logic [gsd_pkg::RATE_W-1:0] mag_z;
   logic [gsd_pkg::SMP_W-1:0]  smp_sum_ff;
   logic [gsd_pkg::SMP_W-1:0]  smp_sum_in;
   logic                       failed_ff;

   // magnitudes; the most negative rate maps to 2^23, which still fits
   always_comb begin
      mag_x = rate_x[gsd_pkg::RATE_W-1] ? (~rate_x + 1'b1) : rate_x;
      mag_y = rate_y[gsd_pkg::RATE_W-1] ? (~rate_y + 1'b1) : rate_y;
      mag_z = rate_z[gsd_pkg::RATE_W-1] ? (~rate_z + 1'b1) : rate_z;
      smp_sum_in = gsd_pkg::SMP_W'(mag_x) + gsd_pkg::SMP_W'(mag_y)
                 + gsd_pkg::SMP_W'(mag_z);
   end

   // payload register
   always_ff @(posedge clock) begin
      if (load) begin
         smp_sum_ff <= smp_sum_in;
         failed_ff  <= read_failed;
      end
   end

   assign smp_sum = smp_sum_ff;
   assign failed  = failed_ff;

endmodule

// ----- rtl/core/gyro_stall_detector.sv -----
// ----------------------------------------------------------------------------
// gyro_stall_detector
// Moving-sum stall detector: a chain of SAMPLES cells holds the window of
// per-sample absolute rate sums, a running sum tracks the window and each
// word is classified as moving, stalled, bail-out or sensor error.
// ----------------------------------------------------------------------------
// path: a req word is held in the input register, then in the output register
//   that drives rsp_valid; rsp_stall on a full output register holds it back
// throughput: one word per cycle unless rsp_stall holds a full output register;
//   the window sum update (old tail out, new sample in, threshold compare) is combinational
// reset: registers return to threshold 65536 and bail limit 100, the window
//   to 1.0 per axis in the last slot to leave, count 0; no clearing pass
module gyro_stall_detector #(
   parameter int SAMPLES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [gsd_pkg::RATE_W-1:0]    req_rate_x,
   input  logic signed [gsd_pkg::RATE_W-1:0]    req_rate_y,
   input  logic signed [gsd_pkg::RATE_W-1:0]    req_rate_z,
   input  logic                                 req_read_failed,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [gsd_pkg::THR_W-1:0]            rsp_window_sum,
   output logic [gsd_pkg::COUNT_W-1:0]          rsp_sample_count,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gsd_pkg::INDEX_W-1:0]          csr_index,
   input  logic [gsd_pkg::THR_W-1:0]            csr_data
);

   localparam int SUM_W = gsd_pkg::SMP_W + $clog2(SAMPLES);
   localparam int EXT_W = (SUM_W > gsd_pkg::THR_W) ? SUM_W : gsd_pkg::THR_W + 1;

   // configuration registers
   logic [gsd_pkg::THR_W-1:0]   thr_ff;
   logic [gsd_pkg::LIMIT_W-1:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= gsd_pkg::THR_RESET;
         limit_ff <= gsd_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == gsd_pkg::CSR_STALL_THRESHOLD) begin
            thr_ff <= csr_data;
         end else if (csr_index == gsd_pkg::CSR_BAIL_LIMIT) begin
            limit_ff <= csr_data[gsd_pkg::LIMIT_W-1:0];
         end
      end
   end

   // pipeline handshake
   logic s1_valid_ff;
   logic s1_valid_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic out_free;
   logic s1_move;
   logic s1_load;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign s1_load   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_load ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input stage
   logic [gsd_pkg::SMP_W-1:0] s1_smp;
   logic                      s1_failed;

   gsd_abs_stage u_abs (
      .clock       (clock),
      .load        (s1_load),
      .rate_x      (req_rate_x),
      .rate_y      (req_rate_y),
      .rate_z      (req_rate_z),
      .read_failed (req_read_failed),
      .smp_sum     (s1_smp),
      .failed      (s1_failed)
   );

   // window cell chain; cell 0 is filled last before eviction at reset
   gsd_pkg::cell_ctl_type     cell_ctl;
   logic [gsd_pkg::SMP_W-1:0] cell_q [SAMPLES];

   genvar k;
   generate
      for (k = 0; k < SAMPLES; k++) begin : g_cell
         if (k == 0) begin : g_head
            gsd_cell #(
               .INIT_VAL (gsd_pkg::INIT_SMP)
            ) u_cell (
               .clock   (clock),
               .reset   (reset),
               .ctl     (cell_ctl),
               .smp_in  (s1_smp),
               .smp_out (cell_q[k])
            );
         end else begin : g_body
            gsd_cell #(
               .INIT_VAL (25'd0)
            ) u_cell (
               .clock   (clock),
               .reset   (reset),
               .ctl     (cell_ctl),
               .smp_in  (cell_q[k-1]),
               .smp_out (cell_q[k])
            );
         end
      end
   endgenerate

   // running sum and classification
   logic [SUM_W-1:0]            sum_ff;
   logic [SUM_W-1:0]            sum_in;
   logic [gsd_pkg::COUNT_W-1:0] seen_ff;
   logic [gsd_pkg::COUNT_W-1:0] seen_in;
   logic [SUM_W-1:0]            new_sum;
   logic [SUM_W-1:0]            rep_sum;
   logic [gsd_pkg::THR_W-1:0]   rep_sat;
   logic                        below_thr;
   logic                        over_limit;
   gsd_pkg::status_type         status_w;
   logic                        final_w;

   always_comb begin
      new_sum = sum_ff - SUM_W'(cell_q[SAMPLES-1]) + SUM_W'(s1_smp);
      below_thr  = EXT_W'(new_sum) < EXT_W'(thr_ff);
      over_limit = seen_ff > gsd_pkg::COUNT_W'(limit_ff);
      rep_sum    = s1_failed ? sum_ff : new_sum;
      rep_sat    = (EXT_W'(rep_sum) > EXT_W'(gsd_pkg::SUM_MAX)) ?
                   gsd_pkg::SUM_MAX : gsd_pkg::THR_W'(rep_sum);
      priority if (s1_failed) begin
         status_w = gsd_pkg::STATUS_ERROR;
      end else if (below_thr) begin
         status_w = gsd_pkg::STATUS_STALLED;
      end else if (over_limit) begin
         status_w = gsd_pkg::STATUS_BAIL;
      end else begin
         status_w = gsd_pkg::STATUS_MOVING;
      end
      final_w = (status_w != gsd_pkg::STATUS_MOVING);

      cell_ctl.init  = s1_move && final_w;
      cell_ctl.shift = s1_move && !final_w;

      sum_in  = sum_ff;
      seen_in = seen_ff;
      if (s1_move) begin
         if (final_w) begin
            sum_in  = SUM_W'(gsd_pkg::INIT_SMP);
            seen_in = '0;
         end else begin
            sum_in  = new_sum;
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= SUM_W'(gsd_pkg::INIT_SMP);
         seen_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         seen_ff <= seen_in;
      end
   end

   // output word register
   logic [1:0]                  status_ff;
   logic [gsd_pkg::THR_W-1:0]   wsum_ff;
   logic [gsd_pkg::COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         status_ff <= status_w;
         wsum_ff   <= rep_sat;
         count_ff  <= seen_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_window_sum   = wsum_ff;
   assign rsp_sample_count = count_ff;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gyro stall detector. A short list of directed
// words (reset state, rate extremes, sensor error, window wrap to a stall,
// bail-out, register extremes, unused register indexes) is followed by
// phases of random words under different register settings. Every returned
// word is checked field by field against an in-bench model of the window,
// or against the verdict given in a typed directed row.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLES        = 8;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = 92;
   localparam int MAX_REPORTS    = 10;

   localparam int RATE_W  = gsd_pkg::RATE_W;
   localparam int THR_W   = gsd_pkg::THR_W;
   localparam int LIMIT_W = gsd_pkg::LIMIT_W;
   localparam int COUNT_W = gsd_pkg::COUNT_W;
   localparam int INDEX_W = gsd_pkg::INDEX_W;

   localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
   localparam logic signed [RATE_W-1:0] RATE_MIN = 24'sh800000;
   localparam logic [RATE_W-1:0]        UNIT_Q16 = RATE_W'(gsd_pkg::ONE_Q16);

   // register indexes with no register behind them
   localparam logic [INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
      logic signed [RATE_W-1:0] rate_z;
      logic                     read_failed;
   } rate_word_type;

   typedef struct packed {
      gsd_pkg::status_type  status;
      logic [THR_W-1:0]     window_sum;
      logic [COUNT_W-1:0]   sample_count;
   } verdict_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [THR_W-1:0]   data;
   } reg_write_type;

   typedef enum logic {
      ROW_WORD,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type  kind;
      rate_word_type word;
      logic          typed;
      verdict_type   verdict;
      reg_write_type write;
   } plan_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [RATE_W-1:0]   req_rate_x = '0;
   logic signed [RATE_W-1:0]   req_rate_y = '0;
   logic signed [RATE_W-1:0]   req_rate_z = '0;
   logic                       req_read_failed = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b1;
   logic [1:0]                 rsp_status;
   logic [THR_W-1:0]           rsp_window_sum;
   logic [COUNT_W-1:0]         rsp_sample_count;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [INDEX_W-1:0]         csr_index = '0;
   logic [THR_W-1:0]           csr_data = '0;

   gyro_stall_detector #(
      .SAMPLES(SAMPLES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rate_x(req_rate_x),
      .req_rate_y(req_rate_y),
      .req_rate_z(req_rate_z),
      .req_read_failed(req_read_failed),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_window_sum(rsp_window_sum),
      .rsp_sample_count(rsp_sample_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model of the window, count and registers
   logic [RATE_W-1:0]  abs_x [SAMPLES];
   logic [RATE_W-1:0]  abs_y [SAMPLES];
   logic [RATE_W-1:0]  abs_z [SAMPLES];
   longint unsigned    window_total;
   int unsigned        next_slot;
   logic [COUNT_W-1:0] words_seen;
   logic [THR_W-1:0]   stall_level = gsd_pkg::THR_RESET;
   logic [LIMIT_W-1:0] bail_level  = gsd_pkg::LIMIT_RESET;

   verdict_type pending_verdicts[$];
   int          mismatch_count = 0;
   int          quiet_left = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int          idle_cycles = 0;

   function automatic void restart_window();
      for (int i = 0; i < SAMPLES; i++) begin
         abs_x[i] = '0;
         abs_y[i] = '0;
         abs_z[i] = '0;
      end
      abs_x[0] = UNIT_Q16;
      abs_y[0] = UNIT_Q16;
      abs_z[0] = UNIT_Q16;
      window_total = 3 * longint'(UNIT_Q16);
      next_slot = 1 % SAMPLES;
      words_seen = '0;
   endfunction

   // magnitude of a rate; the most negative one still fits in 24 bits
   function automatic logic [RATE_W-1:0] magnitude(logic signed [RATE_W-1:0] r);
      logic signed [RATE_W:0] wide;
      wide = r;
      if (wide < 0)
         wide = -wide;
      return wide[RATE_W-1:0];
   endfunction

   function automatic logic [THR_W-1:0] reported_sum();
      return (window_total > longint'(gsd_pkg::SUM_MAX)) ? gsd_pkg::SUM_MAX
                                                         : window_total[THR_W-1:0];
   endfunction

   function automatic verdict_type predict_verdict(rate_word_type w);
      verdict_type        v;
      logic [RATE_W-1:0]  ax, ay, az;
      int unsigned        s;
      // sensor error: nothing stored, report the old window
      if (w.read_failed) begin
         v.status = gsd_pkg::STATUS_ERROR;
         v.window_sum = reported_sum();
         v.sample_count = words_seen;
         restart_window();
         return v;
      end
      ax = magnitude(w.rate_x);
      ay = magnitude(w.rate_y);
      az = magnitude(w.rate_z);
      s = next_slot;
      // old slot leaves the window, new word enters
      window_total = window_total - abs_x[s] - abs_y[s] - abs_z[s];
      window_total = window_total + ax + ay + az;
      abs_x[s] = ax;
      abs_y[s] = ay;
      abs_z[s] = az;
      v.window_sum = reported_sum();
      v.sample_count = words_seen;
      if (window_total < longint'(stall_level)) begin
         v.status = gsd_pkg::STATUS_STALLED;
         restart_window();
      end else if (words_seen > bail_level) begin
         v.status = gsd_pkg::STATUS_BAIL;
         restart_window();
      end else begin
         v.status = gsd_pkg::STATUS_MOVING;
         next_slot = (s + 1) % SAMPLES;
         words_seen = words_seen + 1'b1;
      end
      return v;
   endfunction

   function automatic void apply_write(reg_write_type w);
      case (w.index)
         gsd_pkg::CSR_STALL_THRESHOLD: stall_level = w.data;
         gsd_pkg::CSR_BAIL_LIMIT:      bail_level = w.data[LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // random stimulus
   function automatic int unsigned pick_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic signed [RATE_W-1:0] draw_rate(bit quiet);
      logic signed [RATE_W-1:0] r;
      if (quiet) begin
         r = RATE_W'($urandom_range(0, 63));
         if ($urandom_range(0, 1) != 0)
            r = -r;
         return r;
      end
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: r = RATE_MAX;
               1: r = RATE_MIN;
               2: r = '0;
               3: r = 24'sd1;
               default: r = -24'sd1;
            endcase
         end
         1, 2: r = RATE_W'(int'($urandom_range(0, 131072)) - 65536);
         default: r = RATE_W'($urandom());
      endcase
      return r;
   endfunction

   // motion with runs of near-zero rates long enough to flush the window
   function automatic rate_word_type draw_word();
      rate_word_type w;
      bit            quiet;
      if (quiet_left == 0 && $urandom_range(0, 7) == 0)
         quiet_left = $urandom_range(SAMPLES, SAMPLES + 4);
      quiet = (quiet_left != 0);
      if (quiet)
         quiet_left--;
      w.rate_x = draw_rate(quiet);
      w.rate_y = draw_rate(quiet);
      w.rate_z = draw_rate(quiet);
      w.read_failed = ($urandom_range(0, 31) == 0);
      return w;
   endfunction

   // directed rows
   function automatic plan_row_type word_row(logic signed [RATE_W-1:0] x,
                                             logic signed [RATE_W-1:0] y,
                                             logic signed [RATE_W-1:0] z,
                                             logic failed);
      plan_row_type r;
      r.kind = ROW_WORD;
      r.word = '{x, y, z, failed};
      r.typed = 1'b0;
      r.verdict = '0;
      r.write = '0;
      return r;
   endfunction

   function automatic plan_row_type typed_row(logic signed [RATE_W-1:0] x,
                                              logic signed [RATE_W-1:0] y,
                                              logic signed [RATE_W-1:0] z,
                                              logic failed, gsd_pkg::status_type st,
                                              int unsigned sum, int unsigned cnt);
      plan_row_type r;
      r = word_row(x, y, z, failed);
      r.typed = 1'b1;
      r.verdict = '{st, THR_W'(sum), COUNT_W'(cnt)};
      return r;
   endfunction

   function automatic plan_row_type write_row(logic [INDEX_W-1:0] idx,
                                              logic [THR_W-1:0] data);
      plan_row_type r;
      r = word_row('0, '0, '0, 1'b0);
      r.kind = ROW_WRITE;
      r.write = '{idx, data};
      return r;
   endfunction

   // drivers
   task automatic send_word(input rate_word_type w, input bit typed,
                            input verdict_type given);
      verdict_type want;
      int unsigned gap;
      gap = pick_gap(req_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rate_x <= w.rate_x;
      req_rate_y <= w.rate_y;
      req_rate_z <= w.rate_z;
      req_read_failed <= w.read_failed;
      want = predict_verdict(w);
      pending_verdicts.push_back(typed ? given : want);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input reg_write_type writes[$]);
      foreach (writes[i]) begin
         csr_valid <= 1'b1;
         csr_index <= writes[i].index;
         csr_data <= writes[i].data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         apply_write(writes[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // settings per phase: extremes first, then reset values, then random
   task automatic reprogram(input int phase);
      reg_write_type      writes[$];
      reg_write_type      spare;
      logic [THR_W-1:0]   thr;
      logic [LIMIT_W-1:0] lim;
      logic [THR_W-1:0]   lim_data;
      case (phase)
         0: begin
            thr = '0;
            lim = '1;
         end
         1: begin
            thr = gsd_pkg::SUM_MAX;
            lim = '0;
         end
         2: begin
            thr = gsd_pkg::THR_RESET;
            lim = gsd_pkg::LIMIT_RESET;
         end
         default: begin
            case ($urandom_range(0, 2))
               0: thr = THR_W'($urandom_range(1, 262144));
               1: thr = THR_W'($urandom());
               default: thr = THR_W'($urandom_range(0, 4096));
            endcase
            lim = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom())
                                              : LIMIT_W'($urandom_range(0, 40));
         end
      endcase
      // upper data bits are dont-care for the bail limit
      lim_data = THR_W'($urandom());
      lim_data[LIMIT_W-1:0] = lim;
      if ($urandom_range(0, 1) != 0) begin
         writes.push_back('{gsd_pkg::CSR_STALL_THRESHOLD, thr});
         writes.push_back('{gsd_pkg::CSR_BAIL_LIMIT, lim_data});
      end else begin
         writes.push_back('{gsd_pkg::CSR_BAIL_LIMIT, lim_data});
         writes.push_back('{gsd_pkg::CSR_STALL_THRESHOLD, thr});
      end
      if ($urandom_range(0, 1) != 0) begin
         spare.index = ($urandom_range(0, 1) != 0) ? CSR_SPARE_A : CSR_SPARE_B;
         spare.data = THR_W'($urandom());
         if ($urandom_range(0, 1) != 0)
            writes.push_front(spare);
         else
            writes.push_back(spare);
      end
      drain();
      program_regs(writes);
   endtask

   // stimulus
   initial begin
      plan_row_type  plan[$];
      reg_write_type one[$];
      restart_window();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // error straight after reset, then the extremes while moving
      plan.push_back(typed_row(RATE_MAX, RATE_MAX, RATE_MAX, 1'b1,
                               gsd_pkg::STATUS_ERROR, 196608, 0));
      plan.push_back(typed_row('0, '0, '0, 1'b0, gsd_pkg::STATUS_MOVING, 196608, 0));
      plan.push_back(typed_row(RATE_MAX, RATE_MAX, RATE_MAX, 1'b0,
                               gsd_pkg::STATUS_MOVING, 25362429, 1));
      plan.push_back(typed_row(RATE_MIN, RATE_MIN, RATE_MIN, 1'b0,
                               gsd_pkg::STATUS_MOVING, 50528253, 2));
      plan.push_back(word_row(-24'sd1, 24'sd1, RATE_MAX, 1'b0));
      plan.push_back(word_row(24'sd12345, -24'sd54321, '0, 1'b0));
      plan.push_back(word_row(24'sd7, RATE_MIN, 24'sd9, 1'b1));
      // zeros until the initial slot is overwritten: window wraps into a stall
      for (int i = 0; i < SAMPLES - 1; i++)
         plan.push_back(word_row('0, '0, '0, 1'b0));
      plan.push_back(typed_row('0, '0, '0, 1'b0, gsd_pkg::STATUS_STALLED, 0,
                               SAMPLES - 1));
      // bail-out with a zero limit
      plan.push_back(write_row(gsd_pkg::CSR_BAIL_LIMIT, '0));
      plan.push_back(word_row('0, '0, '0, 1'b0));
      plan.push_back(typed_row(24'sd1, 24'sd2, 24'sd3, 1'b0, gsd_pkg::STATUS_BAIL,
                               196614, 1));
      // largest threshold stalls even full-scale motion
      plan.push_back(write_row(gsd_pkg::CSR_STALL_THRESHOLD, gsd_pkg::SUM_MAX));
      plan.push_back(typed_row(RATE_MAX, RATE_MIN, RATE_MAX, 1'b0,
                               gsd_pkg::STATUS_STALLED, 25362430, 0));
      // zero threshold, then writes to unused indexes must change nothing
      plan.push_back(write_row(gsd_pkg::CSR_STALL_THRESHOLD, '0));
      plan.push_back(write_row(CSR_SPARE_A, gsd_pkg::SUM_MAX));
      plan.push_back(write_row(CSR_SPARE_B, gsd_pkg::SUM_MAX));
      plan.push_back(word_row('0, '0, '0, 1'b0));
      plan.push_back(word_row(RATE_MIN, '0, '0, 1'b0));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            drain();
            one.delete();
            one.push_back(plan[i].write);
            program_regs(one);
         end else begin
            send_word(plan[i].word, plan[i].typed, plan[i].verdict);
         end
      end

      // random phases
      for (int p = 0; p < PHASES; p++) begin
         reprogram(p);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         repeat (PHASE_WORDS) send_word(draw_word(), 1'b0, '0);
      end

      drain();
      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // result side stall
   initial begin
      int unsigned gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = pick_gap(rsp_calm);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   // compare each returned word with the oldest expectation
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("tb_top: unexpected word status %0d sum %0d count %0d",
                        rsp_status, rsp_window_sum, rsp_sample_count);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_status !== want.status || rsp_window_sum !== want.window_sum ||
                rsp_sample_count !== want.sample_count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("tb_top: mismatch: want status %0d sum %0d count %0d, %s %0d %0d %0d",
                           want.status, want.window_sum, want.sample_count,
                           "got status/sum/count", rsp_status, rsp_window_sum,
                           rsp_sample_count);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

endmodule

// ----- sim.f -----
rtl/core/gsd_pkg.sv
rtl/core/gsd_cell.sv
rtl/core/gsd_abs_stage.sv
rtl/core/gyro_stall_detector.sv
sim/tb_top.sv
